/* hw/rtl/url_dec_pkg.sv */
// ----------------------------------------------------------------------------
// url_dec_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package url_dec_pkg;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned LENGTH_BITS  = 16;
  localparam int unsigned SLOTS        = 4;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LF      = 8'h66;
  localparam logic [7:0] CASE_MASK  = 8'hDF;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_terminator;
    logic             overflow;
    logic [15:0]      source_length;
  } result_t;

  typedef struct packed {
    logic [1:0]       held_count;
    logic [7:0]       held_digit;
    logic [CNT_W-1:0] emitted_count;
  } dec_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_UA) v = (c & CASE_MASK) - CH_UA + 8'd10;
    else            v = c - CH_ZERO;
    return v[3:0];
  endfunction

endpackage

/* hw/rtl/url_dec_decode.sv */
// ----------------------------------------------------------------------------
// url_dec_decode
// Decodes one source byte against the lookahead state: builds the decoded
// bytes it releases, gates them by the remaining capacity, and forms the
// next lookahead state.
// ----------------------------------------------------------------------------
module url_dec_decode (
  input  logic [7:0]              char_byte,
  input  logic                    is_final,
  input  logic [15:0]             capacity,
  input  url_dec_pkg::dec_state_t state,
  output url_dec_pkg::dec_state_t state_next,
  output logic [7:0]              cand [3],
  output logic [1:0]              n_emit
);
  import url_dec_pkg::*;

  logic [1:0]       pre_n;
  logic [7:0]       pre0;
  logic [7:0]       pre1;
  logic             f_n;
  logic [7:0]       f_byte;
  logic             f_hold;
  logic [1:0]       n_cand;
  logic [CNT_W-1:0] room;
  logic             c_hex;

  assign c_hex = is_hex(char_byte);

  always_comb begin
    pre_n      = 2'd0;
    pre0       = CH_PERCENT;
    pre1       = state.held_digit;
    f_n        = 1'b0;
    f_byte     = char_byte;
    f_hold     = 1'b0;
    state_next = state;
    state_next.held_count = HELD_NONE;

    // fresh decode of the current byte, used unless a held sequence eats it
    if (char_byte == CH_PERCENT) begin
      if (is_final) f_n = 1'b1;
      else          f_hold = 1'b1;
    end else if (char_byte == CH_PLUS) begin
      f_n    = 1'b1;
      f_byte = CH_SPACE;
    end else begin
      f_n = 1'b1;
    end

    unique case (state.held_count)
      HELD_PCT: begin
        if (c_hex) begin
          f_hold = 1'b0;
          if (is_final) begin
            pre_n = 2'd1;
            f_n   = 1'b1;
          end else begin
            f_n   = 1'b0;
            state_next.held_digit = char_byte;
            state_next.held_count = HELD_DIGIT;
          end
        end else begin
          pre_n = 2'd1;
        end
      end
      HELD_DIGIT: begin
        if (c_hex) begin
          f_hold = 1'b0;
          f_n    = 1'b1;
          f_byte = {hex_value(state.held_digit), hex_value(char_byte)};
        end else begin
          pre_n = 2'd2;
        end
      end
      default: ;
    endcase

    if (f_hold) state_next.held_count = HELD_PCT;

    cand[0] = f_byte;
    cand[1] = f_byte;
    cand[2] = f_byte;
    if (pre_n == 2'd1) begin
      cand[0] = pre0;
    end else if (pre_n == 2'd2) begin
      cand[0] = pre0;
      cand[1] = pre1;
    end
    n_cand = pre_n + {1'b0, f_n};

    room   = (capacity > state.emitted_count) ? capacity - state.emitted_count - 1'b1 : '0;
    n_emit = (room < CNT_W'(n_cand)) ? room[1:0] : n_cand;

    state_next.emitted_count = is_final ? '0 : state.emitted_count + CNT_W'(n_emit);
    if (is_final) state_next.held_count = HELD_NONE;
  end

endmodule

/* hw/rtl/url_percent_decoder_core.sv */
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// URL percent decoder: one source byte per beat in, decoded bytes and a
// per-string terminator beat out.
// ----------------------------------------------------------------------------
// Path: each input beat is registered, then decoded into the result buffer.
// Throughput: one input beat per cycle while each byte yields at most one
//   result and the output is not stalled; a byte yielding k results (up to 4)
//   holds the input until the 4-entry result buffer drains, one beat per unstalled cycle.
// Reset (rst, synchronous): empties the pipeline, clears lookahead and
//   counters, and sets capacity to 65535.
module url_percent_decoder_core #(
  parameter int unsigned LENGTH_BITS = url_dec_pkg::LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_terminator,
  output logic        overflow,
  output logic [15:0] source_length
);
  import url_dec_pkg::*;

  localparam int unsigned CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam logic [LENGTH_BITS-1:0] SrcMax = '1;

  logic [15:0]            cap;
  logic                   q_valid;
  logic [7:0]             q_byte;
  logic                   q_final;
  dec_state_t             st;
  dec_state_t             st_next;
  logic [LENGTH_BITS-1:0] src_count;
  logic [LENGTH_BITS-1:0] src_next;
  logic [CW-1:0]          src_ext;
  logic [15:0]            len;
  logic [7:0]             cand [3];
  logic [1:0]             n_emit;
  result_t                slots [SLOTS];
  result_t                res [SLOTS];
  logic [2:0]             cnt;
  logic                   take;
  logic                   advance;
  logic                   load;
  result_t                term;

  url_dec_decode u_decode (
    .char_byte  (q_byte),
    .is_final   (q_final),
    .capacity   (cap),
    .state      (st),
    .state_next (st_next),
    .cand       (cand),
    .n_emit     (n_emit)
  );

  assign cfg_ready = 1'b1;
  assign take      = out_valid && !out_stall;
  assign advance   = (cnt == 3'd0) || (cnt == 3'd1 && take);
  assign load      = q_valid && advance;
  assign in_stall  = q_valid && !advance;

  assign src_next = (src_count < SrcMax) ? src_count + 1'b1 : src_count;
  assign src_ext  = CW'(src_next);
  assign len      = (src_ext > CW'(16'hFFFF)) ? 16'hFFFF : src_ext[15:0];

  always_comb begin
    term.out_byte      = 8'd0;
    term.is_terminator = 1'b1;
    term.overflow      = (len >= cap);
    term.source_length = len;
    for (int k = 0; k < SLOTS; k++) slots[k] = term;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(n_emit)) begin
        slots[k]          = '0;
        slots[k].out_byte = cand[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= 16'hFFFF;
      q_valid   <= 1'b0;
      cnt       <= 3'd0;
      st.held_count    <= HELD_NONE;
      st.emitted_count <= '0;
      src_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) cap <= capacity;

      if (in_valid && !in_stall) begin
        q_valid <= 1'b1;
        q_byte  <= char_byte;
        q_final <= is_final;
      end else if (advance) begin
        q_valid <= 1'b0;
      end

      if (load) begin
        st        <= st_next;
        src_count <= q_final ? '0 : src_next;
        res       <= slots;
        cnt       <= 3'({1'b0, n_emit}) + 3'({2'b0, q_final});
      end else if (take) begin
        // shift the buffer down one beat
        for (int k = 0; k < SLOTS - 1; k++) res[k] <= res[k+1];
        cnt <= cnt - 3'd1;
      end
    end
  end

  assign out_valid     = (cnt != 3'd0);
  assign out_byte      = res[0].out_byte;
  assign is_terminator = res[0].is_terminator;
  assign overflow      = res[0].overflow;
  assign source_length = res[0].source_length;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result buffer count out of range");

  a_held_code: assert property (@(posedge clk) disable iff (rst)
    st.held_count != 2'd3)
    else $error("unused lookahead code");

  a_q_hold: assert property (@(posedge clk) disable iff (rst)
    q_valid && !advance |=> q_valid && $stable(q_byte) && $stable(q_final))
    else $error("input register lost a held byte");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    load && q_final |=> st.held_count == HELD_NONE && st.emitted_count == '0)
    else $error("string end did not clear decoder state");

endmodule
